// File: hw/rtl/mkds_pkg.sv
// Package for the max_k_digit_subsequence block: sizes, constants and request types.
// No dependencies; every other file takes names from here by scope.
package mkds_pkg;

  localparam int KEEP    = 12;                 // digits kept per line
  localparam int IDX_W   = $clog2(KEEP + 1);   // width of a cell index
  localparam int DIGIT_W = 4;
  localparam int LEN_W   = 8;
  localparam int VALUE_W = 40;
  localparam int TOTAL_W = 64;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
  localparam logic [LEN_W-1:0]   LEN_RESET  = 8'd100;
  localparam logic [LEN_W-1:0]   POS_MAX    = 8'd255;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] line_value;
    logic [TOTAL_W-1:0] total;
  } out_req_t;

  // control broadcast to every cell
  typedef struct packed {
    logic               en;
    logic               clear;
    logic [DIGIT_W-1:0] digit;
    logic [LEN_W-1:0]   remaining;
  } cell_ctl_t;

  // what a cell hands to the cell above it
  typedef struct packed {
    logic               valid;
    logic               stays;
    logic [VALUE_W-1:0] prefix;
  } cell_link_t;

endpackage

// File: hw/rtl/mkds_cell.sv
// One stack entry of the kept-digit row: digit, prefix value and valid bit.
// Depends on mkds_pkg for sizes and the control and link structs.
module mkds_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mkds_pkg::cell_ctl_t           ctl,
  input  logic [mkds_pkg::IDX_W-1:0]    idx,
  input  mkds_pkg::cell_link_t          below,
  input  logic                          above_gone,
  output mkds_pkg::cell_link_t          up,
  output logic                          gone,
  output logic                          target,
  output logic [mkds_pkg::VALUE_W-1:0]  new_prefix
);

  logic                           valid_r, valid_nxt;
  logic [mkds_pkg::DIGIT_W-1:0]   digit_r;
  logic [mkds_pkg::VALUE_W-1:0]   prefix_r;
  logic [mkds_pkg::LEN_W:0]       depth_sum;
  logic                           pop_ok;
  logic                           popped;
  logic                           stays;

  // pop only while the rest of the line can still refill the stack
  assign depth_sum = (mkds_pkg::LEN_W + 1)'(idx) + {1'b0, ctl.remaining};
  assign pop_ok    = valid_r && (digit_r < ctl.digit) &&
                     (depth_sum >= (mkds_pkg::LEN_W + 1)'(mkds_pkg::KEEP));
  assign popped    = pop_ok && above_gone;
  assign stays     = valid_r && !popped;
  assign gone      = !stays;
  assign target    = !stays && below.stays;

  // prefix * 10 + digit, wrapping at the value width
  assign new_prefix = {below.prefix[mkds_pkg::VALUE_W-4:0], 3'b000}
                    + {below.prefix[mkds_pkg::VALUE_W-2:0], 1'b0}
                    + mkds_pkg::VALUE_W'(ctl.digit);

  assign up.valid  = valid_r;
  assign up.stays  = stays;
  assign up.prefix = prefix_r;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.en) begin
      valid_nxt = ctl.clear ? 1'b0 : (stays || target);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && target) begin
      digit_r  <= ctl.digit;
      prefix_r <= new_prefix;
    end
  end

endmodule

// File: hw/rtl/max_k_digit_subsequence.sv
// Results: out_valid rises once a line's value has moved from stage one into the output register.
// Throughput: one digit per cycle while in_stall is low, set by the pop chain through the row of KEEP cells.
// A result waiting under out_stall does not block digits; a second one waits in stage one.
// Reset (synchronous, rst_n low) empties the stack, zeroes position and total, and sets
// line_length to 100. Depends on mkds_pkg and mkds_cell.
module max_k_digit_subsequence (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mkds_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mkds_pkg::out_req_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mkds_pkg::LEN_W-1:0]  cfg_data
);

  localparam int K = mkds_pkg::KEEP;

  // configuration and line position
  logic [mkds_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [mkds_pkg::LEN_W-1:0]   pos_r, pos_nxt;
  logic [mkds_pkg::LEN_W-1:0]   remaining;
  logic [mkds_pkg::DIGIT_W-1:0] digit_sat;

  // result pipeline: stage one holds the line value, the output register adds the total
  logic                         s1_valid_r, s1_valid_nxt;
  logic [mkds_pkg::VALUE_W-1:0] s1_value_r, s1_value_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mkds_pkg::out_req_t           out_data_r, out_data_nxt;
  logic [mkds_pkg::TOTAL_W-1:0] total_r, total_nxt;

  logic accept;
  logic out_take;
  logic s1_ready;

  // cell row
  mkds_pkg::cell_ctl_t          ctl;
  mkds_pkg::cell_link_t         link [0:K];
  logic [K:0]                   gone;
  logic [K-1:0]                 target;
  logic [K-1:0]                 cell_valid;
  logic [mkds_pkg::VALUE_W-1:0] new_prefix [0:K-1];
  logic [mkds_pkg::VALUE_W-1:0] pushed_value;
  logic [mkds_pkg::VALUE_W-1:0] line_value;

  // advance the output register when it is empty or being taken
  assign out_take  = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_take;
  assign in_stall  = !s1_ready;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // clamp digits above nine
  assign digit_sat = (in_data.digit > mkds_pkg::DIGIT_MAX) ? mkds_pkg::DIGIT_MAX : in_data.digit;

  // digits left in the line, the current one included, floored at zero
  assign remaining = (len_r > pos_r) ? (len_r - pos_r) : '0;

  assign ctl.en        = accept;
  assign ctl.clear     = in_data.last;
  assign ctl.digit     = digit_sat;
  assign ctl.remaining = remaining;

  // the bottom cell builds on an empty prefix; nothing sits above the top cell
  assign link[0].valid  = 1'b1;
  assign link[0].stays  = 1'b1;
  assign link[0].prefix = '0;
  assign gone[K]        = 1'b1;

  for (genvar i = 0; i < K; i++) begin : g_cell
    mkds_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .idx        (mkds_pkg::IDX_W'(i)),
      .below      (link[i]),
      .above_gone (gone[i+1]),
      .up         (link[i+1]),
      .gone       (gone[i]),
      .target     (target[i]),
      .new_prefix (new_prefix[i])
    );
    assign cell_valid[i] = link[i+1].valid;
  end

  // pick the pushed prefix; at most one cell takes the digit
  always_comb begin
    pushed_value = '0;
    for (int i = 0; i < K; i++) begin
      if (target[i]) begin
        pushed_value = pushed_value | new_prefix[i];
      end
    end
  end

  // a full stack with no push keeps its top as the line's value
  assign line_value = (|target) ? pushed_value : link[K].prefix;

  always_comb begin
    len_nxt = len_r;
    if (cfg_valid && cfg_ready) begin
      len_nxt = cfg_data;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_data.last) begin
        pos_nxt = '0;
      end else if (pos_r != mkds_pkg::POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_value_nxt = s1_value_r;
    if (accept && in_data.last) begin
      s1_valid_nxt = 1'b1;
      s1_value_nxt = line_value;
    end else if (out_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    total_nxt     = total_r;
    if (out_take) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        total_nxt               = total_r + mkds_pkg::TOTAL_W'(s1_value_r);
        out_data_nxt.line_value = s1_value_r;
        out_data_nxt.total      = total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= mkds_pkg::LEN_RESET;
      pos_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    s1_value_r <= s1_value_nxt;
    out_data_r <= out_data_nxt;
  end

  // at most one cell takes the digit
  a_one_target : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(target))
    else $error("more than one cell took the digit");

  // the stack stays contiguous from the bottom
  a_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("stack has a hole");

  // drop the whole stack after the last digit of a line
  a_clear : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last |=> cell_valid == '0)
    else $error("stack not cleared at end of line");

  // hold input only while both result slots are full and out_stall holds the output
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  // a blocked stage-one result is not lost
  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("stage-one result dropped under stall");

endmodule
